/* hw/rtl/dq_pkg.sv */
// Shared types, constants and index arithmetic for the double-ended queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_LIST       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // latch the request and prefetch its first entry
		logic exec;     // carry out the latched request, emit its first result
		logic step;     // emit the next listed entry
	} dq_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic in_legal; // the offered command code means something
		logic list_go;  // latched request is a list with more than one entry
		logic list_end; // the entry being emitted is the last one of the list
	} dq_sts_t;

	// ring index plus offset, offset at most DEPTH
	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
			input logic [SUM_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = {1'b0, idx} + off;
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on dq_pkg, dq_ctrl and dq_dpath.
//
//   channel   | ports                              | handshake
//   ----------+------------------------------------+-------------------------------
//   request   | cmd, data_value                    | taken when start && !busy
//   result    | status, value_out, last            | done high for one cycle each
//
// A push or pop request runs in two steps: the first latches the request and
// prefetches the addressed entry from the ring, the second updates head and
// count and loads the result register. A list request emits one result per
// stored entry (one for an empty queue), one after another through the single
// read port of the ring. Each result shows on the outputs the cycle after it
// is produced while the next request may already be taken. Reset empties the
// queue at once; the ring contents stay undefined until written. The receiver
// cannot stall; undefined command codes are dropped without a result.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import dq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               cmd,
	input  logic signed [DATA_W-1:0] data_value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] value_out,
	output logic                     last
);

	dq_ctl_t ctl;
	dq_sts_t sts;

	// sequence each request
	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// hold the ring, advance the pointers, form results
	dq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.data_value (data_value),
		.sts        (sts),
		.status     (status),
		.value_out  (value_out),
		.last       (last)
	);

endmodule

`default_nettype wire

/* hw/rtl/dq_ctrl.sv */
// Sequencing state machine of the double-ended queue.
// Depends on dq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl import dq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dq_sts_t sts,
	output dq_ctl_t ctl,
	output logic    busy,
	output logic    done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LIST
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		ctl.accept = (state_q == S_IDLE) && start && sts.in_legal;
		ctl.exec   = (state_q == S_EXEC);
		ctl.step   = (state_q == S_LIST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start && sts.in_legal) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= sts.list_go ? S_LIST : S_IDLE;
				end
				S_LIST: begin
					done_q <= 1'b1;
					if (sts.list_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/dq_dpath.sv */
// Datapath of the double-ended queue: entry ring, head and count, result registers.
// Depends on dq_pkg; driven by dq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module dq_dpath import dq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dq_ctl_t                  ctl,
	input  logic [2:0]               cmd,
	input  logic signed [DATA_W-1:0] data_value,
	output dq_sts_t                  sts,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] value_out,
	output logic                     last
);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  off_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] rd_q;
	status_t           status_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;

	logic             full;
	logic             empty;
	logic [IDX_W-1:0] acc_addr;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] rear_wr;
	logic [IDX_W-1:0] next_rd;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign head_dec = idx_add(head_q, SUM_W'(DEPTH - 1));
	assign rear_wr  = idx_add(head_q, SUM_W'(count_q));
	assign next_rd  = ctl.exec ? idx_add(head_q, SUM_W'(1)) : idx_add(head_q, SUM_W'(off_q));

	always_comb begin
		if (cmd == CMD_POP_REAR) begin
			acc_addr = idx_add(head_q, SUM_W'(count_q) - SUM_W'(1));
		end else begin
			acc_addr = head_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rear_wr;
		if (ctl.exec && !full) begin
			if (cmd_q == CMD_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = head_dec;
			end else if (cmd_q == CMD_PUSH_REAR) begin
				wr_en = 1'b1;
			end
		end
	end

	always_comb begin
		sts.in_legal = (cmd <= CMD_LIST);
		sts.list_go  = (cmd_q == CMD_LIST) && (count_q > CNT_W'(1));
		sts.list_end = (off_q == count_q);
	end

	// entry ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_q;
		end
		if (ctl.accept) begin
			rd_q <= mem[acc_addr];
		end else if (ctl.step || (ctl.exec && cmd_q == CMD_LIST)) begin
			rd_q <= mem[next_rd];
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= cmd_t'(cmd);
			data_q <= data_value;
		end
		if (ctl.exec) begin
			case (cmd_q)
				CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
					status_q <= full ? ST_FULL : ST_OK;
					value_q  <= '0;
					last_q   <= 1'b1;
				end
				CMD_POP_FRONT, CMD_POP_REAR: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
					value_q  <= empty ? '0 : rd_q;
					last_q   <= 1'b1;
				end
				CMD_LIST: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
					value_q  <= empty ? '0 : rd_q;
					last_q   <= (count_q <= CNT_W'(1));
				end
				default: begin
					status_q <= ST_OK;
					value_q  <= '0;
					last_q   <= 1'b1;
				end
			endcase
		end else if (ctl.step) begin
			status_q <= ST_OK;
			value_q  <= rd_q;
			last_q   <= sts.list_end;
		end
	end

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
		end else begin
			if (ctl.exec) begin
				off_q <= CNT_W'(2);
				case (cmd_q)
					CMD_PUSH_FRONT: begin
						if (!full) begin
							head_q  <= head_dec;
							count_q <= count_q + CNT_W'(1);
						end
					end
					CMD_PUSH_REAR: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					CMD_POP_FRONT: begin
						if (!empty) begin
							head_q  <= idx_add(head_q, SUM_W'(1));
							count_q <= count_q - CNT_W'(1);
						end
					end
					CMD_POP_REAR: begin
						if (!empty) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (ctl.step) begin
				off_q <= off_q + CNT_W'(1);
			end
		end
	end

	assign status    = status_q;
	assign value_out = value_q;
	assign last      = last_q;

endmodule

`default_nettype wire
